FILE: src/lwpw_pkg.sv
// shared types, command codes and sizes for the lcd window pixel writer
// no dependencies; the rtl files refer to this package by scoped names, the testbench imports it
package lwpw_pkg;

  // panel geometry
  localparam int PANEL_ROWS = 176;
  localparam int PANEL_COLS = 220;
  localparam int XW = $clog2(PANEL_ROWS + 1);
  localparam int YW = $clog2(PANEL_COLS + 1);

  // queue sizes
  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // bus command codes
  localparam logic [15:0] CMD_ENTRY  = 16'h0003;
  localparam logic [15:0] CMD_HADDR  = 16'h0020;
  localparam logic [15:0] CMD_VADDR  = 16'h0021;
  localparam logic [15:0] CMD_PIXEL  = 16'h0022;
  localparam logic [15:0] CMD_CEND   = 16'h0036;
  localparam logic [15:0] CMD_CSTART = 16'h0037;
  localparam logic [15:0] CMD_PEND   = 16'h0038;
  localparam logic [15:0] CMD_PSTART = 16'h0039;

  // entry-mode bit that selects page-first stepping
  localparam int ENTRY_PAGE_FIRST_BIT = 3;

  typedef enum logic [3:0] {
    SEL_NONE,
    SEL_ENTRY,
    SEL_HADDR,
    SEL_VADDR,
    SEL_PIXEL,
    SEL_CEND,
    SEL_CSTART,
    SEL_PEND,
    SEL_PSTART
  } sel_t;

  typedef struct packed {
    logic        is_parameter;
    logic [15:0] bus_word;
  } in_item_t;

  typedef struct packed {
    logic        pixel_written;
    logic [15:0] pixel_address;
    logic [15:0] pixel_value;
    logic        frame_end;
  } out_item_t;

  // classified parameter word handed from front to back
  typedef struct packed {
    sel_t        sel;
    logic [15:0] word;
  } op_t;

endpackage

FILE: src/lwpw_front.sv
// front end: accepts bus words, tracks the selected command, classifies parameters
// depends on lwpw_pkg; feeds lwpw_op_queue
module lwpw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lwpw_pkg::in_item_t request,
  input  logic              queue_full,
  output logic              op_push,
  output lwpw_pkg::op_t     op
);

  lwpw_pkg::sel_t selected;
  lwpw_pkg::sel_t decoded;
  logic           accept;

  assign accept = push && !queue_full;

  always_comb begin
    unique case (request.bus_word)
      lwpw_pkg::CMD_ENTRY:  decoded = lwpw_pkg::SEL_ENTRY;
      lwpw_pkg::CMD_HADDR:  decoded = lwpw_pkg::SEL_HADDR;
      lwpw_pkg::CMD_VADDR:  decoded = lwpw_pkg::SEL_VADDR;
      lwpw_pkg::CMD_PIXEL:  decoded = lwpw_pkg::SEL_PIXEL;
      lwpw_pkg::CMD_CEND:   decoded = lwpw_pkg::SEL_CEND;
      lwpw_pkg::CMD_CSTART: decoded = lwpw_pkg::SEL_CSTART;
      lwpw_pkg::CMD_PEND:   decoded = lwpw_pkg::SEL_PEND;
      lwpw_pkg::CMD_PSTART: decoded = lwpw_pkg::SEL_PSTART;
      default:              decoded = lwpw_pkg::SEL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected <= lwpw_pkg::SEL_NONE;
    end else if (accept && !request.is_parameter) begin
      selected <= decoded;
    end
  end

  // parameters with nothing selected are dropped here
  assign op_push = accept && request.is_parameter && (selected != lwpw_pkg::SEL_NONE);
  assign op.sel  = selected;
  assign op.word = request.bus_word;

endmodule

FILE: src/lwpw_op_queue.sv
// short queue of classified parameter words between front and back
// depends on lwpw_pkg
module lwpw_op_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lwpw_pkg::op_t wr_op,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output lwpw_pkg::op_t rd_op
);

  localparam int PW = lwpw_pkg::OPQ_PTR_W;
  localparam int CW = lwpw_pkg::OPQ_CNT_W;

  lwpw_pkg::op_t  mem [lwpw_pkg::OPQ_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign full     = (count == CW'(lwpw_pkg::OPQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = mem[rptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(lwpw_pkg::OPQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(lwpw_pkg::OPQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/lwpw_back.sv
// back end: window registers, address counters, pixel address stage, result queue
// depends on lwpw_pkg; drains lwpw_op_queue
module lwpw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  input  lwpw_pkg::op_t      op,
  output logic               op_take,
  output logic               empty,
  input  logic               pop,
  output lwpw_pkg::out_item_t result
);

  localparam int XW = lwpw_pkg::XW;
  localparam int YW = lwpw_pkg::YW;
  localparam int PW = lwpw_pkg::OUTQ_PTR_W;
  localparam int CW = lwpw_pkg::OUTQ_CNT_W;

  // window and counter state
  logic [15:0] column_start;
  logic [15:0] column_end;
  logic [15:0] page_start;
  logic [15:0] page_end;
  logic [31:0] col_extent;
  logic [31:0] page_extent;
  logic [31:0] column_offset;
  logic [31:0] page_offset;
  logic        page_first_order;

  // address stage
  logic          st_valid;
  logic          st_written;
  logic [XW-1:0] st_x;
  logic [YW-1:0] st_y;
  logic [15:0]   st_value;
  logic          st_frame;

  // result queue
  lwpw_pkg::out_item_t outq [lwpw_pkg::OUTQ_DEPTH];
  logic [PW-1:0]       wptr;
  logic [PW-1:0]       rptr;
  logic [CW-1:0]       count;

  logic        is_pixel;
  logic        credit;
  logic [31:0] word32;
  logic [31:0] x32;
  logic [31:0] y32;
  logic        on_panel;
  logic [31:0] col_inc;
  logic [31:0] page_inc;
  logic        col_wrap;
  logic        page_wrap;
  logic [31:0] column_offset_next;
  logic [31:0] page_offset_next;
  logic        frame;
  logic [31:0] addr_full;
  lwpw_pkg::out_item_t st_item;
  logic        do_pop;

  assign word32   = {16'b0, op.word};
  assign is_pixel = (op.sel == lwpw_pkg::SEL_PIXEL);
  assign credit   = ({1'b0, count} + (CW + 1)'(st_valid)) < (CW + 1)'(lwpw_pkg::OUTQ_DEPTH);
  assign op_take  = op_valid && (!is_pixel || credit);

  assign x32      = {16'b0, column_start} + column_offset;
  assign y32      = {16'b0, page_start} + page_offset;
  assign on_panel = (x32 < 32'(lwpw_pkg::PANEL_ROWS)) && (y32 < 32'(lwpw_pkg::PANEL_COLS));

  assign col_inc   = column_offset + 32'd1;
  assign page_inc  = page_offset + 32'd1;
  assign col_wrap  = col_inc > col_extent;
  assign page_wrap = page_inc > page_extent;

  always_comb begin
    if (!page_first_order) begin
      column_offset_next = col_wrap ? '0 : col_inc;
      page_offset_next   = col_wrap ? (page_wrap ? '0 : page_inc) : page_offset;
      frame              = col_wrap && page_wrap;
    end else begin
      page_offset_next   = page_wrap ? '0 : page_inc;
      column_offset_next = page_wrap ? (col_wrap ? '0 : col_inc) : column_offset;
      frame              = page_wrap && col_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_start     <= '0;
      column_end       <= 16'(lwpw_pkg::PANEL_ROWS - 1);
      page_start       <= '0;
      page_end         <= 16'(lwpw_pkg::PANEL_COLS - 1);
      col_extent       <= 32'(lwpw_pkg::PANEL_ROWS - 1);
      page_extent      <= 32'(lwpw_pkg::PANEL_COLS - 1);
      column_offset    <= '0;
      page_offset      <= '0;
      page_first_order <= 1'b0;
    end else if (op_take) begin
      unique case (op.sel)
        lwpw_pkg::SEL_ENTRY: begin
          page_first_order <= op.word[lwpw_pkg::ENTRY_PAGE_FIRST_BIT];
        end
        lwpw_pkg::SEL_HADDR: begin
          column_offset <= word32 - {16'b0, column_start};
        end
        lwpw_pkg::SEL_VADDR: begin
          page_offset <= word32 - {16'b0, page_start};
        end
        lwpw_pkg::SEL_PIXEL: begin
          column_offset <= column_offset_next;
          page_offset   <= page_offset_next;
        end
        lwpw_pkg::SEL_CEND: begin
          column_end <= op.word;
          col_extent <= word32 - {16'b0, column_start};
        end
        lwpw_pkg::SEL_CSTART: begin
          column_start <= op.word;
          col_extent   <= {16'b0, column_end} - word32;
        end
        lwpw_pkg::SEL_PEND: begin
          page_end    <= op.word;
          page_extent <= word32 - {16'b0, page_start};
        end
        lwpw_pkg::SEL_PSTART: begin
          page_start  <= op.word;
          page_extent <= {16'b0, page_end} - word32;
        end
        default: begin
        end
      endcase
    end
  end

  // address stage, off-panel pixels carry zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= op_take && is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && is_pixel) begin
      st_written <= on_panel;
      st_x       <= on_panel ? x32[XW-1:0] : '0;
      st_y       <= on_panel ? y32[YW-1:0] : '0;
      st_value   <= on_panel ? op.word : '0;
      st_frame   <= frame;
    end
  end

  assign addr_full = 32'(st_x) * 32'(lwpw_pkg::PANEL_COLS) + 32'(st_y);

  assign st_item.pixel_written = st_written;
  assign st_item.pixel_address = addr_full[15:0];
  assign st_item.pixel_value   = st_value;
  assign st_item.frame_end     = st_frame;

  // result queue, space for the stage is reserved when the pixel is taken
  assign empty  = (count == '0);
  assign result = outq[rptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (st_valid) begin
      outq[wptr] <= st_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (st_valid) begin
        wptr <= (wptr == PW'(lwpw_pkg::OUTQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(lwpw_pkg::OUTQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (st_valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !st_valid) begin
        count <= count - 1'b1;
      end
    end
  end

  a_outq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    st_valid |-> (count < CW'(lwpw_pkg::OUTQ_DEPTH) || do_pop))
    else $error("result queue written while full");

  a_pixel_needs_credit: assert property (@(posedge clk) disable iff (rst)
    (op_take && is_pixel) |-> credit)
    else $error("pixel taken without result queue space");

  a_stage_feeds_queue: assert property (@(posedge clk) disable iff (rst)
    (op_take && is_pixel) |=> st_valid)
    else $error("taken pixel did not reach the address stage");

  a_dropped_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.pixel_written) |->
      (result.pixel_address == 16'd0 && result.pixel_value == 16'd0))
    else $error("dropped pixel carries nonzero address or value");

endmodule

FILE: src/lwpw_top_dummy_placeholder_unused.sv
// address-stage helper is folded into lwpw_back; this file holds the top level
// depends on lwpw_pkg, lwpw_front, lwpw_op_queue, lwpw_back
//
//  channel   direction  handshake          payload
//  request   in         push / full        lwpw_pkg::in_item_t
//  result    out        pop / empty        lwpw_pkg::out_item_t
//
// one bus word is taken per cycle while full is low; full rises only when the two-entry op queue
// is full, which happens when the back end holds pixels for lack of result space
// a pixel request reaches the result port through the op queue, the counter update
// into the address stage, and the address multiply into the four-entry result queue
// reset (synchronous, rst high) sets the full panel window, zero counters,
// column-first stepping and no selected command, and empties both queues
// non-pixel parameters and command words produce no result
module lcd_window_pixel_writer (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  lwpw_pkg::in_item_t  request,
  output logic                empty,
  input  logic                pop,
  output lwpw_pkg::out_item_t result
);

  // front to queue
  logic          op_push;
  lwpw_pkg::op_t front_op;

  // queue to back
  logic          q_valid;
  lwpw_pkg::op_t q_op;
  logic          q_take;

  // front: command decode and parameter classification
  lwpw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .request    (request),
    .queue_full (full),
    .op_push    (op_push),
    .op         (front_op)
  );

  // decoupling queue, its full flag is the request-side backpressure
  lwpw_op_queue u_op_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (op_push),
    .wr_op    (front_op),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_op    (q_op)
  );

  // back: window state, counters, pixel address and result queue
  lwpw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_valid),
    .op       (q_op),
    .op_take  (q_take),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

FILE: test/tb_lcd_window_pixel_writer.sv
`timescale 1ns / 100ps
// self-checking testbench for lcd_window_pixel_writer: directed table, then random bus traffic
// depends on lwpw_pkg and the lcd_window_pixel_writer rtl only
module tb_lcd_window_pixel_writer;
  import lwpw_pkg::*;

  // bus word kinds, matching the is_parameter bit
  localparam bit CMD_WORD   = 1'b0;
  localparam bit PARAM_WORD = 1'b1;

  // a command code the controller does not decode
  localparam logic [15:0] CMD_BOGUS = 16'h00FF;

  localparam int BUS_WORDS   = 1350;       // random requests to send
  localparam int CALM_WORDS  = 150;        // tail of the run with no idling
  localparam int CYCLE_LIMIT = 200000;     // far above the slowest legal run
  localparam int TAIL_CYCLES = 12;         // pipe drain plus margin

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  request = '0;
  out_item_t result;

  lcd_window_pixel_writer dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor state: window registers and counters as the controller holds them
  // counters and extents are 32-bit, wrapping, compared unsigned
  // ---------------------------------------------------------------------
  sel_t        cur_sel        = SEL_NONE;
  logic [31:0] win_col_start  = 32'd0;
  logic [31:0] win_col_end    = 32'(PANEL_ROWS - 1);
  logic [31:0] win_page_start = 32'd0;
  logic [31:0] win_page_end   = 32'(PANEL_COLS - 1);
  logic [31:0] col_ofs        = 32'd0;
  logic [31:0] page_ofs       = 32'd0;
  bit          page_first     = 1'b0;

  // pixel writes still owed by the controller, oldest first
  out_item_t pixel_writes_due[$];

  int  errors     = 0;
  int  words_sent = 0;
  int  cycles     = 0;
  bit  calm       = 1'b0;   // set near the end: no idling on either side
  int  pop_hold   = 0;

  // applies one bus word to the window state; returns 1 when it makes a pixel write
  function automatic bit window_step(input in_item_t it, output out_item_t px);
    logic [31:0] col_ext;
    logic [31:0] page_ext;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] addr;
    bit          wrapped_both;
    px = '0;
    if (it.is_parameter == CMD_WORD) begin
      case (it.bus_word)
        CMD_ENTRY:  cur_sel = SEL_ENTRY;
        CMD_HADDR:  cur_sel = SEL_HADDR;
        CMD_VADDR:  cur_sel = SEL_VADDR;
        CMD_PIXEL:  cur_sel = SEL_PIXEL;
        CMD_CEND:   cur_sel = SEL_CEND;
        CMD_CSTART: cur_sel = SEL_CSTART;
        CMD_PEND:   cur_sel = SEL_PEND;
        CMD_PSTART: cur_sel = SEL_PSTART;
        default:    cur_sel = SEL_NONE;
      endcase
      return 1'b0;
    end
    case (cur_sel)
      SEL_ENTRY:  page_first = it.bus_word[ENTRY_PAGE_FIRST_BIT];
      SEL_HADDR:  col_ofs = {16'd0, it.bus_word} - win_col_start;
      SEL_VADDR:  page_ofs = {16'd0, it.bus_word} - win_page_start;
      SEL_CEND:   win_col_end = {16'd0, it.bus_word};
      SEL_CSTART: win_col_start = {16'd0, it.bus_word};
      SEL_PEND:   win_page_end = {16'd0, it.bus_word};
      SEL_PSTART: win_page_start = {16'd0, it.bus_word};
      SEL_PIXEL: begin
        col_ext      = win_col_end - win_col_start;
        page_ext     = win_page_end - win_page_start;
        x            = win_col_start + col_ofs;
        y            = win_page_start + page_ofs;
        wrapped_both = 1'b0;
        // first counter steps, its wrap steps the second one
        if (!page_first) begin
          col_ofs = col_ofs + 32'd1;
          if (col_ofs > col_ext) begin
            col_ofs  = 32'd0;
            page_ofs = page_ofs + 32'd1;
            if (page_ofs > page_ext) begin
              page_ofs     = 32'd0;
              wrapped_both = 1'b1;
            end
          end
        end else begin
          page_ofs = page_ofs + 32'd1;
          if (page_ofs > page_ext) begin
            page_ofs = 32'd0;
            col_ofs  = col_ofs + 32'd1;
            if (col_ofs > col_ext) begin
              col_ofs      = 32'd0;
              wrapped_both = 1'b1;
            end
          end
        end
        // off-panel pixels are dropped with address and value zeroed
        if (x < 32'(PANEL_ROWS) && y < 32'(PANEL_COLS)) begin
          addr             = x * 32'(PANEL_COLS) + y;
          px.pixel_written = 1'b1;
          px.pixel_address = addr[15:0];
          px.pixel_value   = it.bus_word;
        end
        px.frame_end = wrapped_both;
        return 1'b1;
      end
      default: ;  // no command selected: word is ignored
    endcase
    return 1'b0;
  endfunction

  // drives one request and holds it until the controller takes it;
  // a typed expectation replaces the predicted one for table rows
  task automatic send_word(input bit kind, input logic [15:0] w,
                           input bit typed = 1'b0, input out_item_t want = '0);
    in_item_t  req;
    out_item_t px;
    bit        has_px;
    req.is_parameter = kind;
    req.bus_word     = w;
    // idle burst before the request
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push    <= 1'b1;
    request <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    has_px = window_step(req, px);
    if (has_px) pixel_writes_due.push_back(typed ? want : px);
    words_sent++;
  endtask

  // sender holds off until every owed pixel write has come out
  task automatic wait_for_pixels_out();
    push <= 1'b0;
    @(posedge clk);
    while (pixel_writes_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // directed table: extremes, every command, the special cases
  // typed rows carry the result that can be read off directly
  // ---------------------------------------------------------------------
  typedef struct {
    bit          kind;
    logic [15:0] word;
    bit          typed;
    out_item_t   want;
  } bus_row_t;

  localparam int DIRECTED_ROWS = 28;
  bus_row_t directed_rows [DIRECTED_ROWS] = '{
    // parameter before any command is ignored
    '{PARAM_WORD, 16'h1234, 1'b0, '0},
    '{CMD_WORD,   CMD_PIXEL, 1'b0, '0},
    // first pixel after reset lands at the origin
    '{PARAM_WORD, 16'hFFFF, 1'b1, '{1'b1, 16'd0, 16'hFFFF, 1'b0}},
    // column counter stepped once: one row further in memory
    '{PARAM_WORD, 16'h0000, 1'b1, '{1'b1, 16'd220, 16'h0000, 1'b0}},
    '{CMD_WORD,   CMD_HADDR, 1'b0, '0},
    '{PARAM_WORD, 16'd175,   1'b0, '0},
    '{CMD_WORD,   CMD_VADDR, 1'b0, '0},
    '{PARAM_WORD, 16'd219,   1'b0, '0},
    '{CMD_WORD,   CMD_PIXEL, 1'b0, '0},
    // far corner of the panel, both counters wrap
    '{PARAM_WORD, 16'hA5A5, 1'b1, '{1'b1, 16'd38719, 16'hA5A5, 1'b1}},
    '{CMD_WORD,   CMD_HADDR, 1'b0, '0},
    '{PARAM_WORD, 16'hFFFF, 1'b0, '0},
    '{CMD_WORD,   CMD_PIXEL, 1'b0, '0},
    // column far off the panel: pixel dropped
    '{PARAM_WORD, 16'h5A5A, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
    '{CMD_WORD,   CMD_ENTRY, 1'b0, '0},
    '{PARAM_WORD, 16'h0008, 1'b0, '0},
    '{CMD_WORD,   CMD_PIXEL, 1'b0, '0},
    '{PARAM_WORD, 16'h1111, 1'b1, '{1'b1, 16'd1, 16'h1111, 1'b0}},
    '{CMD_WORD,   CMD_CSTART, 1'b0, '0},
    '{PARAM_WORD, 16'd160,    1'b0, '0},
    '{CMD_WORD,   CMD_PEND,   1'b0, '0},
    '{PARAM_WORD, 16'd1,      1'b0, '0},
    // page start past page end: extent wraps to a huge value
    '{CMD_WORD,   CMD_PSTART, 1'b0, '0},
    '{PARAM_WORD, 16'd3,      1'b0, '0},
    '{CMD_WORD,   CMD_CEND,   1'b0, '0},
    '{PARAM_WORD, 16'd161,    1'b0, '0},
    // unknown command deselects, its parameter is ignored
    '{CMD_WORD,   CMD_BOGUS,  1'b0, '0},
    '{PARAM_WORD, 16'h7777,   1'b0, '0}
  };

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    logic [15:0] c0, c1, p0, p1;
    int          pick;
    bit          mid_drained;
    mid_drained = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].kind, directed_rows[i].word,
                directed_rows[i].typed, directed_rows[i].want);
    // a few pixels into the odd window left by the table
    send_word(CMD_WORD, CMD_PIXEL);
    repeat (3) send_word(PARAM_WORD, 16'($urandom_range(0, 65535)));
    wait_for_pixels_out();

    words_sent = 0;
    while (words_sent < BUS_WORDS) begin
      if (words_sent >= BUS_WORDS - CALM_WORDS) calm = 1'b1;
      // once in the middle, let the result side drain completely
      if (!mid_drained && words_sent > BUS_WORDS / 2) begin
        wait_for_pixels_out();
        mid_drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // pixel burst
        send_word(CMD_WORD, CMD_PIXEL);
        repeat ($urandom_range(1, 16)) send_word(PARAM_WORD, 16'($urandom_range(0, 65535)));
      end else if (pick < 64) begin
        // new window, mostly small and near the panel, then home the counters
        if ($urandom_range(0, 9) == 0) begin
          c0 = 16'd0; c1 = 16'(PANEL_ROWS - 1); p0 = 16'd0; p1 = 16'(PANEL_COLS - 1);
        end else begin
          c0 = 16'($urandom_range(0, 180));
          p0 = 16'($urandom_range(0, 224));
          c1 = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                            : c0 + 16'($urandom_range(0, 5));
          p1 = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                            : p0 + 16'($urandom_range(0, 5));
        end
        send_word(CMD_WORD, CMD_CSTART); send_word(PARAM_WORD, c0);
        send_word(CMD_WORD, CMD_CEND);   send_word(PARAM_WORD, c1);
        send_word(CMD_WORD, CMD_PSTART); send_word(PARAM_WORD, p0);
        send_word(CMD_WORD, CMD_PEND);   send_word(PARAM_WORD, p1);
        send_word(CMD_WORD, CMD_HADDR);  send_word(PARAM_WORD, c0);
        send_word(CMD_WORD, CMD_VADDR);  send_word(PARAM_WORD, p0);
      end else if (pick < 74) begin
        // move the address counters, sometimes anywhere in 16 bits
        send_word(CMD_WORD, CMD_HADDR);
        send_word(PARAM_WORD, ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 200)));
        send_word(CMD_WORD, CMD_VADDR);
        send_word(PARAM_WORD, ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 230)));
      end else if (pick < 82) begin
        // entry mode, bit 3 picks the stepping order
        send_word(CMD_WORD, CMD_ENTRY);
        send_word(PARAM_WORD, 16'($urandom_range(0, 65535)));
      end else if (pick < 90) begin
        // raw noise on the bus
        repeat ($urandom_range(1, 4))
          send_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      end else if (pick < 95) begin
        // command abandoned for another one
        send_word(CMD_WORD, ($urandom_range(0, 1) == 1) ? CMD_CSTART : CMD_PSTART);
        send_word(CMD_WORD, CMD_PIXEL);
        send_word(PARAM_WORD, 16'($urandom_range(0, 65535)));
      end else begin
        // unknown command, then parameters that must be dropped
        send_word(CMD_WORD, ($urandom_range(0, 1) == 1) ? CMD_BOGUS
                                                        : 16'($urandom_range(64, 65535)));
        repeat ($urandom_range(1, 3)) send_word(PARAM_WORD, 16'($urandom_range(0, 65535)));
      end
    end

    wait_for_pixels_out();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("lcd_window_pixel_writer regression: pass");
    else
      $display("lcd_window_pixel_writer regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // result side: random pop stalls, each accepted result checked in order
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t due;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pixel_writes_due.size() == 0) begin
          $error("pixel write with none outstanding: %p", result);
          errors++;
        end else begin
          due = pixel_writes_due.pop_front();
          if (result.pixel_written !== due.pixel_written) begin
            $error("pixel_written: expected %0d, got %0d", due.pixel_written,
                   result.pixel_written);
            errors++;
          end
          if (result.pixel_address !== due.pixel_address) begin
            $error("pixel_address: expected %0d, got %0d", due.pixel_address,
                   result.pixel_address);
            errors++;
          end
          if (result.pixel_value !== due.pixel_value) begin
            $error("pixel_value: expected %h, got %h", due.pixel_value, result.pixel_value);
            errors++;
          end
          if (result.frame_end !== due.frame_end) begin
            $error("frame_end: expected %0d, got %0d", due.frame_end, result.frame_end);
            errors++;
          end
        end
      end
      // random stall bursts on pop
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        pop_hold = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lcd_window_pixel_writer regression: fail");
      $finish;
    end
  end

endmodule
